FILE: hw/rtl/kmwc_pkg.sv
// ----------------------------------------------------------------------------
// kmwc_pkg
// Shared types and constants of the keying matte window clip block.
// ----------------------------------------------------------------------------
package kmwc_pkg;

  // Sample format and default frame limits
  localparam int SampleBits = 16;
  localparam int MaxRadius  = 8;
  localparam int MaxWidth   = 2048;
  localparam int MaxHeight  = 2048;

  localparam logic [SampleBits-1:0] FullScale = '1;

  // Configuration port
  localparam int CfgIndexBits = 3;
  localparam int CfgDataBits  = 16;

  // Divide by ten through a reciprocal: q = (n * 6554) >> 16
  localparam int Div10Mul   = 6554;
  localparam int Div10Shift = 16;

  typedef enum logic [CfgIndexBits-1:0] {
    CfgRadius    = 3'd0,
    CfgWidth     = 3'd1,
    CfgHeight    = 3'd2,
    CfgTolerance = 3'd3,
    CfgBlack     = 3'd4,
    CfgWhite     = 3'd5,
    CfgEdge      = 3'd6
  } cfg_reg_e;

  // Input word
  typedef struct packed {
    logic [SampleBits-1:0] sample;
    logic                  drain;
  } kmwc_in_t;

  // Output word
  typedef struct packed {
    logic [SampleBits-1:0] matte;
    logic                  steady;
    logic                  frame_last;
  } kmwc_out_t;

  // Back end status seen by the front end
  typedef struct packed {
    logic reading;   // window scan in progress, line store must not change
  } back_stat_t;

endpackage

FILE: hw/rtl/keying_matte_window_clip_core.sv
// ----------------------------------------------------------------------------
// keying_matte_window_clip_core
// Matte clean-up: window steadiness test with black/white clip or edge matte.
// ----------------------------------------------------------------------------
// Matte samples enter in raster order and each pixel leaves once its window
// (side 2*radius-1, clipped at the borders) is in the line store; drain words
// flush the pending pixels at frame end. Every input word passes the front
// end states in turn: store write, two rank multiplies and the decision. A
// word that releases a pixel then holds the input until the back end has
// read the window through the single store read port. Clipping a steady
// pixel between the clip levels uses the bit-serial divider, overlapped
// with the next input word. The output word is registered, so input is
// taken while a result waits.
module keying_matte_window_clip_core #(
  parameter int MAX_RADIUS = kmwc_pkg::MaxRadius,
  parameter int MAX_WIDTH  = kmwc_pkg::MaxWidth,
  parameter int MAX_HEIGHT = kmwc_pkg::MaxHeight
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  kmwc_pkg::kmwc_in_t                   in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output kmwc_pkg::kmwc_out_t                  out_data_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [kmwc_pkg::CfgIndexBits-1:0]    cfg_index_i,
  input  logic [kmwc_pkg::CfgDataBits-1:0]     cfg_data_i
);
  import kmwc_pkg::*;

  localparam int RING = 2 * MAX_RADIUS;
  localparam int RGW  = $clog2(RING);
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RHW  = $clog2(MAX_HEIGHT);
  localparam int RW   = $clog2(MAX_RADIUS + 1);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int JW   = CW + RHW + RGW;
  localparam int RadiusRst = (MAX_RADIUS < 3) ? MAX_RADIUS : 3;
  localparam int WidthRst  = (MAX_WIDTH < 2048) ? MAX_WIDTH : 2048;
  localparam int HeightRst = (MAX_HEIGHT < 2048) ? MAX_HEIGHT : 2048;

  // Configuration registers
  logic [RW-1:0] radius_q;
  logic [WW-1:0] width_q;
  logic [HW-1:0] height_q;
  logic [SampleBits-1:0] tolerance_q, black_q, white_q;
  logic          edge_q;

  logic [RW-1:0] radius_sat;
  logic [WW-1:0] width_sat;
  logic [HW-1:0] height_sat;
  logic [3:0]    radius_raw;
  logic [11:0]   size_raw;

  // Saturate sizes and radius on write
  always_comb begin
    radius_raw = cfg_data_i[3:0];
    size_raw   = cfg_data_i[11:0];
    radius_sat = (32'(radius_raw) > 32'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(radius_raw);
    if (size_raw == '0) begin
      width_sat  = WW'(1);
      height_sat = HW'(1);
    end else begin
      width_sat  = (32'(size_raw) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(size_raw);
      height_sat = (32'(size_raw) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(size_raw);
    end
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q    <= RW'(RadiusRst);
      width_q     <= WW'(WidthRst);
      height_q    <= HW'(HeightRst);
      tolerance_q <= SampleBits'(6554);
      black_q     <= '0;
      white_q     <= FullScale;
      edge_q      <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgRadius:    radius_q    <= radius_sat;
        CfgWidth:     width_q     <= width_sat;
        CfgHeight:    height_q    <= height_sat;
        CfgTolerance: tolerance_q <= cfg_data_i;
        CfgBlack:     black_q     <= cfg_data_i;
        CfgWhite:     white_q     <= cfg_data_i;
        CfgEdge:      edge_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Internal connections
  logic                  wr_en, rd_en;
  logic [RGW-1:0]        wr_ring, rd_ring;
  logic [CW-1:0]         wr_col, rd_col;
  logic [SampleBits-1:0] wr_data, rd_data;
  logic                  job_push, job_pop, job_empty, job_full;
  logic [JW-1:0]         job_in, job_out;
  back_stat_t            back_stat;

  kmwc_front #(
    .MAX_RADIUS(MAX_RADIUS), .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .radius_i(radius_q), .width_i(width_q), .height_i(height_q),
    .wr_en_o(wr_en), .wr_ring_o(wr_ring), .wr_col_o(wr_col), .wr_data_o(wr_data),
    .job_push_o(job_push), .job_o(job_in), .job_empty_i(job_empty),
    .stat_i(back_stat)
  );

  kmwc_line_store #(
    .RING_ROWS(RING), .MAX_WIDTH(MAX_WIDTH)
  ) u_store (
    .clk_i,
    .wr_en_i(wr_en), .wr_ring_i(wr_ring), .wr_col_i(wr_col), .wr_data_i(wr_data),
    .rd_en_i(rd_en), .rd_ring_i(rd_ring), .rd_col_i(rd_col), .rd_data_o(rd_data)
  );

  kmwc_job_fifo #(
    .DW(JW)
  ) u_fifo (
    .clk_i, .rst_ni, .push_i(job_push), .data_i(job_in), .pop_i(job_pop),
    .data_o(job_out), .empty_o(job_empty), .full_o(job_full)
  );

  kmwc_back #(
    .MAX_RADIUS(MAX_RADIUS), .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)
  ) u_back (
    .clk_i, .rst_ni,
    .radius_i(radius_q), .width_i(width_q), .height_i(height_q),
    .tolerance_i(tolerance_q), .black_i(black_q), .white_i(white_q), .edge_i(edge_q),
    .job_empty_i(job_empty), .job_i(job_out), .job_pop_o(job_pop),
    .rd_en_o(rd_en), .rd_ring_o(rd_ring), .rd_col_o(rd_col), .rd_data_i(rd_data),
    .stat_o(back_stat), .out_valid_o, .out_stall_i, .out_data_o
  );

`ifndef ASSERT_OFF
  // no store write while a window is being read
  assert property (@(posedge clk_i) disable iff (!rst_ni) wr_en |-> !back_stat.reading)
    else $error("line store written during window scan");
  // input held off while the back end reads
  assert property (@(posedge clk_i) disable iff (!rst_ni) back_stat.reading |-> in_stall_o)
    else $error("input accepted during window scan");
  // job queue never overflows
  assert property (@(posedge clk_i) disable iff (!rst_ni) job_push |-> !job_full)
    else $error("job queue overflow");
`endif

endmodule

FILE: hw/rtl/kmwc_line_store.sv
// ----------------------------------------------------------------------------
// kmwc_line_store
// Ring of line buffers: one write port, one registered read port.
// ----------------------------------------------------------------------------
module kmwc_line_store #(
  parameter int RING_ROWS = 16,
  parameter int MAX_WIDTH = 2048
) (
  input  logic                                 clk_i,
  input  logic                                 wr_en_i,
  input  logic [$clog2(RING_ROWS)-1:0]         wr_ring_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]         wr_col_i,
  input  logic [kmwc_pkg::SampleBits-1:0]      wr_data_i,
  input  logic                                 rd_en_i,
  input  logic [$clog2(RING_ROWS)-1:0]         rd_ring_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]         rd_col_i,
  output logic [kmwc_pkg::SampleBits-1:0]      rd_data_o
);
  import kmwc_pkg::*;

  logic [SampleBits-1:0] mem [RING_ROWS][MAX_WIDTH];
  logic [SampleBits-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_ring_i][wr_col_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_ring_i][rd_col_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: hw/rtl/kmwc_job_fifo.sv
// ----------------------------------------------------------------------------
// kmwc_job_fifo
// Two-entry queue of pixel jobs between the front and back ends.
// ----------------------------------------------------------------------------
module kmwc_job_fifo #(
  parameter int DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] data_i,
  input  logic          pop_i,
  output logic [DW-1:0] data_o,
  output logic          empty_o,
  output logic          full_o
);
  import kmwc_pkg::*;

  logic [DW-1:0] entry_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;

  // Pointer and fill count
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = entry_q[rd_ptr_q];
  assign empty_o = (count_q == 2'd0);
  assign full_o  = (count_q == 2'd2);

endmodule

FILE: hw/rtl/kmwc_front.sv
// ----------------------------------------------------------------------------
// kmwc_front
// Accepts input words, writes the line store, tracks raster positions and
// decides when the pending output pixel has its whole window.
// ----------------------------------------------------------------------------
module kmwc_front #(
  parameter int MAX_RADIUS = 8,
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              in_valid_i,
  output logic                                              in_stall_o,
  input  kmwc_pkg::kmwc_in_t                                in_data_i,
  input  logic [$clog2(MAX_RADIUS+1)-1:0]                   radius_i,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]                    width_i,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]                   height_i,
  output logic                                              wr_en_o,
  output logic [$clog2(2*MAX_RADIUS)-1:0]                   wr_ring_o,
  output logic [$clog2(MAX_WIDTH)-1:0]                      wr_col_o,
  output logic [kmwc_pkg::SampleBits-1:0]                   wr_data_o,
  output logic                                              job_push_o,
  output logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)+$clog2(2*MAX_RADIUS)-1:0] job_o,
  input  logic                                              job_empty_i,
  input  kmwc_pkg::back_stat_t                              stat_i
);
  import kmwc_pkg::*;

  localparam int RING = 2 * MAX_RADIUS;
  localparam int RGW  = $clog2(RING);
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RHW  = $clog2(MAX_HEIGHT);
  localparam int RW   = $clog2(MAX_RADIUS + 1);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int RKW  = RHW + WW + 1;

  typedef enum logic [4:0] {
    FIdle    = 5'b00001,
    FRankIn  = 5'b00010,
    FRankOut = 5'b00100,
    FDecide  = 5'b01000,
    FWait    = 5'b10000
  } front_state_e;

  front_state_e state_q, state_d;

  logic [CW-1:0]  in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RHW-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic [RGW-1:0] in_ring_q, in_ring_d, out_ring_q, out_ring_d;
  logic           in_done_q, in_done_d;
  logic [RKW-1:0] rank_in_q, rank_in_d, rank_out_q, rank_out_d;

  logic           accept, ready;
  logic [RW-1:0]  reach;
  logic [CW:0]    in_col_inc, out_col_inc, xd, wm1;
  logic [RHW:0]   in_row_inc, out_row_inc, yd, hm1;
  logic [CW-1:0]  ex;
  logic [RHW-1:0] ey;

  assign in_stall_o = (state_q != FIdle);
  assign accept     = in_valid_i && (state_q == FIdle);

  // Store write of a pixel word
  assign wr_en_o   = accept && !in_data_i.drain;
  assign wr_ring_o = in_ring_q;
  assign wr_col_o  = in_col_q;
  assign wr_data_o = in_data_i.sample;

  // Window end of the pending output pixel and the two raster ranks
  always_comb begin
    reach       = (radius_i == '0) ? '0 : radius_i - 1'b1;
    in_col_inc  = (CW+1)'(in_col_q) + 1'b1;
    in_row_inc  = (RHW+1)'(in_row_q) + 1'b1;
    out_col_inc = (CW+1)'(out_col_q) + 1'b1;
    out_row_inc = (RHW+1)'(out_row_q) + 1'b1;
    xd          = (CW+1)'(out_col_q) + (CW+1)'(reach);
    wm1         = (CW+1)'(width_i) - 1'b1;
    yd          = (RHW+1)'(out_row_q) + (RHW+1)'(reach);
    hm1         = (RHW+1)'(height_i) - 1'b1;
    ex          = (xd < wm1) ? CW'(xd) : CW'(wm1);
    ey          = (yd < hm1) ? RHW'(yd) : RHW'(hm1);
    rank_in_d   = RKW'(in_row_q) * RKW'(width_i) + RKW'(in_col_q);
    rank_out_d  = RKW'(ey) * RKW'(width_i) + RKW'(ex);
    ready       = in_done_q || (rank_in_q > rank_out_q);
  end

  // Counters and sequencing
  always_comb begin
    state_d    = state_q;
    in_col_d   = in_col_q;
    in_row_d   = in_row_q;
    in_ring_d  = in_ring_q;
    in_done_d  = in_done_q;
    out_col_d  = out_col_q;
    out_row_d  = out_row_q;
    out_ring_d = out_ring_q;
    job_push_o = 1'b0;
    case (state_q)
      FIdle: begin
        if (accept) begin
          state_d = FRankIn;
          if (!in_data_i.drain) begin
            if (in_col_inc >= (CW+1)'(width_i)) begin
              in_col_d = '0;
              if (in_row_inc >= (RHW+1)'(height_i)) begin
                in_row_d  = '0;
                in_ring_d = '0;
                in_done_d = 1'b1;
              end else begin
                in_row_d  = RHW'(in_row_inc);
                in_ring_d = (in_ring_q == RGW'(RING - 1)) ? '0 : in_ring_q + 1'b1;
              end
            end else begin
              in_col_d = CW'(in_col_inc);
            end
          end
        end
      end
      FRankIn:  state_d = FRankOut;
      FRankOut: state_d = FDecide;
      FDecide: begin
        if (ready) begin
          job_push_o = 1'b1;
          state_d    = FWait;
          if (out_col_inc >= (CW+1)'(width_i)) begin
            out_col_d = '0;
            if (out_row_inc >= (RHW+1)'(height_i)) begin
              out_row_d  = '0;
              out_ring_d = '0;
              in_done_d  = 1'b0;
            end else begin
              out_row_d  = RHW'(out_row_inc);
              out_ring_d = (out_ring_q == RGW'(RING - 1)) ? '0 : out_ring_q + 1'b1;
            end
          end else begin
            out_col_d = CW'(out_col_inc);
          end
        end else begin
          state_d = FIdle;
        end
      end
      FWait: begin
        // hold off writes until the back end has read the window
        if (job_empty_i && !stat_i.reading) begin
          state_d = FIdle;
        end
      end
      default: state_d = FIdle;
    endcase
  end

  assign job_o = {out_col_q, out_row_q, out_ring_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= FIdle;
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_ring_q  <= '0;
      in_done_q  <= 1'b0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_ring_q <= '0;
    end else begin
      state_q    <= state_d;
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      in_ring_q  <= in_ring_d;
      in_done_q  <= in_done_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
      out_ring_q <= out_ring_d;
    end
  end

  // Rank registers
  always_ff @(posedge clk_i) begin
    if (state_q == FRankIn) begin
      rank_in_q <= rank_in_d;
    end
    if (state_q == FRankOut) begin
      rank_out_q <= rank_out_d;
    end
  end

endmodule

FILE: hw/rtl/kmwc_back.sv
// ----------------------------------------------------------------------------
// kmwc_back
// Scans the window of one pixel, one neighbour a cycle, decides steadiness,
// clips (bit-serial divider) or makes an edge matte, holds the output word.
// ----------------------------------------------------------------------------
module kmwc_back #(
  parameter int MAX_RADIUS = 8,
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic [$clog2(MAX_RADIUS+1)-1:0]                   radius_i,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]                    width_i,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]                   height_i,
  input  logic [kmwc_pkg::SampleBits-1:0]                   tolerance_i,
  input  logic [kmwc_pkg::SampleBits-1:0]                   black_i,
  input  logic [kmwc_pkg::SampleBits-1:0]                   white_i,
  input  logic                                              edge_i,
  input  logic                                              job_empty_i,
  input  logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)+$clog2(2*MAX_RADIUS)-1:0] job_i,
  output logic                                              job_pop_o,
  output logic                                              rd_en_o,
  output logic [$clog2(2*MAX_RADIUS)-1:0]                   rd_ring_o,
  output logic [$clog2(MAX_WIDTH)-1:0]                      rd_col_o,
  input  logic [kmwc_pkg::SampleBits-1:0]                   rd_data_i,
  output kmwc_pkg::back_stat_t                              stat_o,
  output logic                                              out_valid_o,
  input  logic                                              out_stall_i,
  output kmwc_pkg::kmwc_out_t                               out_data_o
);
  import kmwc_pkg::*;

  localparam int RING    = 2 * MAX_RADIUS;
  localparam int RGW     = $clog2(RING);
  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int RHW     = $clog2(MAX_HEIGHT);
  localparam int RW      = $clog2(MAX_RADIUS + 1);
  localparam int SXW     = $clog2(2 * MAX_RADIUS);
  localparam int WinMax  = (2 * MAX_RADIUS - 1) * (2 * MAX_RADIUS - 1);
  localparam int CNTW    = $clog2(WinMax + 1);
  localparam int NW      = $clog2(9 * WinMax + 10);
  localparam int PW      = NW + 14;
  localparam int SB      = SampleBits;
  localparam int DCW     = $clog2(SB);

  typedef enum logic [9:0] {
    BIdle  = 10'b0000000001,
    BSetup = 10'b0000000010,
    BTotal = 10'b0000000100,
    BRecip = 10'b0000001000,
    BFix   = 10'b0000010000,
    BScan  = 10'b0000100000,
    BTail  = 10'b0001000000,
    BMap   = 10'b0010000000,
    BDiv   = 10'b0100000000,
    BDone  = 10'b1000000000
  } back_state_e;

  back_state_e state_q, state_d;

  // Job and window bounds
  logic [CW-1:0]   x_q, x0_q, x1_q, j_q;
  logic [RHW-1:0]  y_q, y0_q, y1_q, i_q;
  logic [RGW-1:0]  ring_y_q, ring0_q, ring_i_q;
  logic            empty_q;
  logic [SB-1:0]   v_q;
  logic [CNTW-1:0] total_q, q_est_q, thr_q, cnt_q;
  logic [NW-1:0]   n_q;
  logic            cmp_en_q;

  // Divider and result
  logic [SB-1:0]   rem_q, num_lo_q, quo_q, den_q;
  logic [DCW-1:0]  step_q;
  logic [SB-1:0]   res_q;
  logic            steady_q, last_q;

  // Output register
  logic            out_valid_q;
  kmwc_out_t       out_q;

  logic [CW-1:0]   job_x;
  logic [RHW-1:0]  job_y;
  logic [RGW-1:0]  job_ring;
  logic [RW-1:0]   reach;
  logic [CW:0]     xd, wm1;
  logic [RHW:0]    yd, hm1;
  logic [RGW:0]    ring_back;
  logic [SXW-1:0]  sx, sy;
  logic [NW-1:0]   n_d;
  logic [PW-1:0]   prod;
  logic [SB-1:0]   diff;
  logic            steady, last_pos, out_free, centre;
  logic [2*SB-1:0] num;
  logic [SB:0]     trial;

  assign {job_x, job_y, job_ring} = job_i;

  // Combinational helpers
  always_comb begin
    reach     = (radius_i == '0) ? '0 : radius_i - 1'b1;
    xd        = (CW+1)'(x_q) + (CW+1)'(reach);
    wm1       = (CW+1)'(width_i) - 1'b1;
    yd        = (RHW+1)'(y_q) + (RHW+1)'(reach);
    hm1       = (RHW+1)'(height_i) - 1'b1;
    ring_back = (RGW+1)'(ring_y_q) + (RGW+1)'(RING) - (RGW+1)'(reach);
    if (ring_back >= (RGW+1)'(RING)) begin
      ring_back = ring_back - (RGW+1)'(RING);
    end
    sx        = SXW'(x1_q - x0_q + 1'b1);
    sy        = SXW'(y1_q - y0_q + 1'b1);
    n_d       = NW'(total_q) * NW'(9) + NW'(9);
    prod      = PW'(n_q) * PW'(Div10Mul);
    diff      = (rd_data_i > v_q) ? rd_data_i - v_q : v_q - rd_data_i;
    steady    = (radius_i == '0) || ((thr_q != '0) && (cnt_q >= thr_q));
    num       = ({(v_q - black_i), {SB{1'b0}}}) - (2*SB)'(v_q - black_i);
    trial     = {rem_q, num_lo_q[SB-1]};
    last_pos  = ((i_q == y1_q) && (j_q == x1_q));
    centre    = ((i_q == y_q) && (j_q == x_q));
    out_free  = !out_valid_q || !out_stall_i;
  end

  // Store read requests: centre in setup, then the window
  always_comb begin
    rd_en_o   = 1'b0;
    rd_ring_o = ring_y_q;
    rd_col_o  = x_q;
    if (state_q == BSetup) begin
      rd_en_o = 1'b1;
    end else if (state_q == BScan) begin
      rd_en_o   = 1'b1;
      rd_ring_o = ring_i_q;
      rd_col_o  = j_q;
    end
  end

  assign job_pop_o = (state_q == BIdle) && !job_empty_i;

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      BIdle:  if (!job_empty_i) state_d = BSetup;
      BSetup: state_d = BTotal;
      BTotal: state_d = BRecip;
      BRecip: state_d = BFix;
      BFix: begin
        if ((radius_i == '0) || empty_q) begin
          state_d = BMap;
        end else begin
          state_d = BScan;
        end
      end
      BScan:  if (last_pos) state_d = BTail;
      BTail:  state_d = BMap;
      BMap: begin
        if (edge_i || !steady || (v_q < black_i) || (v_q >= white_i)) begin
          state_d = BDone;
        end else begin
          state_d = BDiv;
        end
      end
      BDiv:   if (step_q == DCW'(SB - 1)) state_d = BDone;
      BDone:  if (out_free) state_d = BIdle;
      default: state_d = BIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BIdle;
      cmp_en_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cmp_en_q <= (state_q == BScan) && !centre;
      if ((state_q == BDone) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      BIdle: begin
        x_q      <= job_x;
        y_q      <= job_y;
        ring_y_q <= job_ring;
      end
      BSetup: begin
        x0_q    <= (x_q >= CW'(reach)) ? x_q - CW'(reach) : '0;
        x1_q    <= (xd < wm1) ? CW'(xd) : CW'(wm1);
        y0_q    <= (y_q >= RHW'(reach)) ? y_q - RHW'(reach) : '0;
        y1_q    <= (yd < hm1) ? RHW'(yd) : RHW'(hm1);
        ring0_q <= (y_q >= RHW'(reach)) ? RGW'(ring_back) : '0;
      end
      BTotal: begin
        v_q     <= rd_data_i;
        empty_q <= (x1_q < x0_q) || (y1_q < y0_q);
        if ((x1_q < x0_q) || (y1_q < y0_q)) begin
          total_q <= '0;
        end else begin
          total_q <= CNTW'(CNTW'(sx) * CNTW'(sy) - 1'b1);
        end
      end
      BRecip: begin
        n_q <= n_d;
      end
      BFix: begin
        q_est_q  <= CNTW'(prod >> Div10Shift);
        i_q      <= y0_q;
        j_q      <= x0_q;
        ring_i_q <= ring0_q;
        cnt_q    <= '0;
      end
      BScan: begin
        if (j_q == x1_q) begin
          j_q      <= x0_q;
          i_q      <= i_q + 1'b1;
          ring_i_q <= (ring_i_q == RGW'(RING - 1)) ? '0 : ring_i_q + 1'b1;
        end else begin
          j_q <= j_q + 1'b1;
        end
      end
      BMap: begin
        steady_q <= steady;
        last_q   <= ((CW+1)'(x_q) + 1'b1 >= (CW+1)'(width_i)) &&
                    ((RHW+1)'(y_q) + 1'b1 >= (RHW+1)'(height_i));
        rem_q    <= num[2*SB-1:SB];
        num_lo_q <= num[SB-1:0];
        den_q    <= white_i - black_i;
        step_q   <= '0;
        if (edge_i) begin
          res_q <= steady ? '0 : FullScale;
        end else if (!steady) begin
          res_q <= v_q;
        end else if (v_q < black_i) begin
          res_q <= '0;
        end else begin
          res_q <= FullScale;
        end
      end
      BDiv: begin
        // restoring division, one quotient bit a cycle
        num_lo_q <= num_lo_q << 1;
        step_q   <= step_q + 1'b1;
        if (trial >= {1'b0, den_q}) begin
          rem_q <= SB'(trial - {1'b0, den_q});
          quo_q <= {quo_q[SB-2:0], 1'b1};
        end else begin
          rem_q <= SB'(trial);
          quo_q <= {quo_q[SB-2:0], 1'b0};
        end
        if (step_q == DCW'(SB - 1)) begin
          res_q <= (trial >= {1'b0, den_q}) ? {quo_q[SB-2:0], 1'b1} : {quo_q[SB-2:0], 1'b0};
        end
      end
      default: ;
    endcase

    // threshold correction after the reciprocal estimate
    if (state_q == BScan || state_q == BTail) begin
      if (state_q == BScan && j_q == x0_q && i_q == y0_q) begin
        thr_q <= ((NW'(q_est_q) * NW'(10)) > n_q) ? q_est_q - 1'b1 : q_est_q;
      end
    end else if (state_q == BMap && (radius_i == '0 || empty_q)) begin
      thr_q <= '0;
    end

    // neighbour compare, one read behind the address
    if (cmp_en_q && (diff < tolerance_i)) begin
      cnt_q <= cnt_q + 1'b1;
    end

    if ((state_q == BDone) && out_free) begin
      out_q.matte      <= res_q;
      out_q.steady     <= steady_q;
      out_q.frame_last <= last_q;
    end
  end

  assign stat_o.reading = (state_q == BSetup) || (state_q == BTotal) ||
                          (state_q == BRecip) || (state_q == BFix) ||
                          (state_q == BScan)  || (state_q == BTail);

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
